>>> hw/rtl/pcal_pkg.sv
package pcal_pkg;

  localparam int AccW     = 48;
  localparam int CoefW    = 32;
  localparam int FracW    = 16;
  localparam int TermW    = 3;
  localparam int CoefRegs = 4;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  typedef enum logic [CfgAddrW-1:0] {
    RegModeSelect = 3'd0,
    RegTermCount  = 3'd1,
    RegCoefZero   = 3'd2,
    RegCoefOne    = 3'd3,
    RegCoefTwo    = 3'd4,
    RegCoefThree  = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    ModeCopy = 1'b0,
    ModePoly = 1'b1
  } mode_e;

  typedef logic signed [CoefW-1:0] coef_t;

  typedef struct packed {
    mode_e                     mode;
    logic [TermW-1:0]          term_count;
    coef_t [CoefRegs-1:0]      coef;
  } cfg_t;

endpackage

>>> hw/rtl/pcal_if.sv
interface pcal_smp_if #(
  parameter int RAW_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [RAW_BITS-1:0] raw_value;

  modport source (output valid, output raw_value, input ready);
  modport sink   (input valid, input raw_value, output ready);
endinterface

interface pcal_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [pcal_pkg::AccW-1:0] calibrated_value;
  logic                             overflow_flag;

  modport source (output valid, output calibrated_value, output overflow_flag, input ready);
  modport sink   (input valid, input calibrated_value, input overflow_flag, output ready);
endinterface

interface pcal_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pcal_pkg::CfgAddrW-1:0]  addr;
  logic [pcal_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> hw/rtl/pcal_cfg.sv
module pcal_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  pcal_cfg_if.sink       cfg_i,
  output pcal_pkg::cfg_t cfg_o
);
  import pcal_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.addr))
        RegModeSelect: cfg_q.mode       <= mode_e'(cfg_i.data[0]);
        RegTermCount:  cfg_q.term_count <= cfg_i.data[TermW-1:0];
        RegCoefZero:   cfg_q.coef[0]    <= coef_t'(cfg_i.data[CoefW-1:0]);
        RegCoefOne:    cfg_q.coef[1]    <= coef_t'(cfg_i.data[CoefW-1:0]);
        RegCoefTwo:    cfg_q.coef[2]    <= coef_t'(cfg_i.data[CoefW-1:0]);
        RegCoefThree:  cfg_q.coef[3]    <= coef_t'(cfg_i.data[CoefW-1:0]);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

endmodule

>>> hw/rtl/pcal_step.sv
module pcal_step #(
  parameter int RAW_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [pcal_pkg::AccW-1:0] acc_i,
  input  logic                             ovf_i,
  input  logic [RAW_BITS-1:0]              raw_i,
  input  pcal_pkg::coef_t                  coef_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [pcal_pkg::AccW-1:0] acc_o,
  output logic                             ovf_o,
  output logic [RAW_BITS-1:0]              raw_o
);
  import pcal_pkg::*;

  localparam int HalfW   = AccW / 2;
  localparam int HiProdW = HalfW + RAW_BITS + 1;
  localparam int LoProdW = HalfW + RAW_BITS;
  localparam int ProdW   = AccW + RAW_BITS + 1;

  // stage 1: split multiply, stage 2: combine and clamp, stage 3: add coefficient and clamp
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [HiProdW-1:0] p_hi_d, p_hi_q;
  logic [LoProdW-1:0]        p_lo_d, p_lo_q;
  logic                      ovf1_q, ovf2_q, ovf3_q;
  logic [RAW_BITS-1:0]       raw1_q, raw2_q, raw3_q;

  logic signed [ProdW-1:0]   prod;
  logic [ProdW-AccW:0]       prod_top;
  logic                      prod_pos_ovf, prod_neg_ovf;
  logic signed [AccW-1:0]    acc2_d, acc2_q;
  logic                      ovf2_d;

  logic signed [AccW:0]      sum;
  logic signed [AccW-1:0]    acc3_d, acc3_q;
  logic                      ovf3_d;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // signed upper half and unsigned lower half of the accumulator
  assign p_hi_d = $signed(acc_i[AccW-1:HalfW]) * $signed({1'b0, raw_i});
  assign p_lo_d = acc_i[HalfW-1:0] * raw_i;

  assign prod     = ($signed(ProdW'(p_hi_q)) <<< HalfW) + $signed(ProdW'(p_lo_q));
  assign prod_top = prod[ProdW-1:AccW-1];
  assign prod_pos_ovf = !prod[ProdW-1] && (|prod_top);
  assign prod_neg_ovf = prod[ProdW-1] && !(&prod_top);

  always_comb begin
    if (prod_pos_ovf) begin
      acc2_d = AccMax;
    end else if (prod_neg_ovf) begin
      acc2_d = AccMin;
    end else begin
      acc2_d = prod[AccW-1:0];
    end
    ovf2_d = ovf1_q || prod_pos_ovf || prod_neg_ovf;
  end

  assign sum = $signed({acc2_q[AccW-1], acc2_q}) + (AccW+1)'(coef_i);

  always_comb begin
    if (sum[AccW] != sum[AccW-1]) begin
      acc3_d = sum[AccW] ? AccMin : AccMax;
      ovf3_d = 1'b1;
    end else begin
      acc3_d = sum[AccW-1:0];
      ovf3_d = ovf2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      p_hi_q <= p_hi_d;
      p_lo_q <= p_lo_d;
      ovf1_q <= ovf_i;
      raw1_q <= raw_i;
    end
    if (rdy2) begin
      acc2_q <= acc2_d;
      ovf2_q <= ovf2_d;
      raw2_q <= raw1_q;
    end
    if (rdy3) begin
      acc3_q <= acc3_d;
      ovf3_q <= ovf3_d;
      raw3_q <= raw2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign acc_o       = acc3_q;
  assign ovf_o       = ovf3_q;
  assign raw_o       = raw3_q;

endmodule

>>> hw/rtl/polynomial_calibration.sv
// polynomial calibration of raw converter samples
// smp_i carries raw_value (RAW_BITS wide, unsigned); res_o returns calibrated_value
// (signed Q31.16, 48 bits) and overflow_flag. both are valid/ready channels, a
// transaction happens at a clock edge with valid and ready high.
// cfg_i writes the registers: 0 mode, 1 term count, 2..5 coefficients c0..c3
// (signed Q15.16). it is always ready; write only while no sample is in flight.
// in polynomial mode the block runs Horner's rule over MAX_TERMS chained step
// units, each three register stages deep (split multiply, combine and clamp, add
// coefficient and clamp). steps at or above the term count see a zero coefficient.
// one sample is taken every cycle as long as results are taken.
// copy mode shows the raw sample shifted into Q31.16 at the pipeline output.
// when res_o stalls each stage holds its transaction and ready backs up stage by
// stage, so empty stages keep filling; nothing is dropped or repeated.
// reset clears the valid bits and the configuration registers; no sample is lost
// at reset exit.
module polynomial_calibration #(
  parameter int MAX_TERMS = 4,
  parameter int RAW_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcal_smp_if.sink   smp_i,
  pcal_res_if.source res_o,
  pcal_cfg_if.sink   cfg_i
);
  import pcal_pkg::*;

  localparam int CopyW = RAW_BITS + FracW;

  cfg_t cfg;

  logic                   ch_valid [MAX_TERMS+1];
  logic                   ch_ready [MAX_TERMS+1];
  logic signed [AccW-1:0] ch_acc   [MAX_TERMS+1];
  logic                   ch_ovf   [MAX_TERMS+1];
  logic [RAW_BITS-1:0]    ch_raw   [MAX_TERMS+1];

  logic [CopyW-1:0]       copy_full;
  logic                   copy_ovf;

  pcal_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign ch_valid[0] = smp_i.valid;
  assign smp_i.ready = ch_ready[0];
  assign ch_acc[0]   = '0;
  assign ch_ovf[0]   = 1'b0;
  assign ch_raw[0]   = smp_i.raw_value;

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_step
    localparam int Idx = MAX_TERMS - 1 - k;
    coef_t coef_eff;

    if (Idx < CoefRegs) begin : g_coef
      assign coef_eff = (TermW'(Idx) < cfg.term_count) ? cfg.coef[Idx] : '0;
    end else begin : g_nocoef
      assign coef_eff = '0;
    end

    pcal_step #(
      .RAW_BITS (RAW_BITS)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (ch_valid[k]),
      .in_ready_o  (ch_ready[k]),
      .acc_i       (ch_acc[k]),
      .ovf_i       (ch_ovf[k]),
      .raw_i       (ch_raw[k]),
      .coef_i      (coef_eff),
      .out_valid_o (ch_valid[k+1]),
      .out_ready_i (ch_ready[k+1]),
      .acc_o       (ch_acc[k+1]),
      .ovf_o       (ch_ovf[k+1]),
      .raw_o       (ch_raw[k+1])
    );
  end

  // copy value only leaves the 48-bit range for samples of 32 bits or more
  assign copy_full = {ch_raw[MAX_TERMS], {FracW{1'b0}}};
  assign copy_ovf  = |(copy_full >> (AccW - 1));

  assign ch_ready[MAX_TERMS] = res_o.ready;
  assign res_o.valid         = ch_valid[MAX_TERMS];

  always_comb begin
    if (cfg.mode == ModeCopy) begin
      res_o.calibrated_value = copy_ovf ? AccMax : $signed(AccW'(copy_full));
      res_o.overflow_flag    = copy_ovf;
    end else begin
      res_o.calibrated_value = ch_acc[MAX_TERMS];
      res_o.overflow_flag    = ch_ovf[MAX_TERMS];
    end
  end

endmodule

>>> hw/rtl/pcal_checker.sv
module pcal_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      smp_valid_i,
  input logic                      smp_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [pcal_pkg::AccW-1:0] res_value_i,
  input logic                      res_ovf_i
);

  // held result stays put until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result withdrawn before transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_value_i) && $stable(res_ovf_i))
    else $error("stalled result changed");

  // a free output slot means the whole pipeline can move, so input must be ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i || res_ready_i |-> smp_ready_i)
    else $error("input stalled while output slot free");

  // nothing comes out straight after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid_i)
    else $error("result valid at reset exit");

  // handshake lines are always known out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({res_valid_i, smp_ready_i, smp_valid_i}))
    else $error("handshake signal unknown");

endmodule

bind polynomial_calibration pcal_checker u_pcal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .smp_valid_i (smp_i.valid),
  .smp_ready_i (smp_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_value_i (res_o.calibrated_value),
  .res_ovf_i   (res_o.overflow_flag)
);
